// ----- sv/casw_pkg.sv -----
// Shared types and constants for the crank angle stimulation window.
// Margin sets, drive levels and configuration register indexes.
// No dependencies.
package casw_pkg;

  localparam int AngleW      = 9;
  localparam int ShiftW      = AngleW + 1;   // angle plus delay, up to 1022
  localparam int LevelW      = 4;
  localparam int MarginW     = 6;            // signed, -10 .. 15
  localparam int ChannelSlots = 4;           // output ports per side
  localparam int CfgIndexW   = 3;
  localparam int CfgDataW    = ChannelSlots * AngleW;

  localparam logic [ShiftW-1:0] FullTurn = ShiftW'(360);

  // configuration register indexes
  localparam logic [CfgIndexW-1:0] REG_PHASE_DELAY  = 3'd0;
  localparam logic [CfgIndexW-1:0] REG_MOD_MASK     = 3'd1;
  localparam logic [CfgIndexW-1:0] REG_LEFT_START   = 3'd2;
  localparam logic [CfgIndexW-1:0] REG_LEFT_STOP    = 3'd3;
  localparam logic [CfgIndexW-1:0] REG_RIGHT_START  = 3'd4;
  localparam logic [CfgIndexW-1:0] REG_RIGHT_STOP   = 3'd5;

  // drive levels in tenths
  localparam logic [LevelW-1:0] LEVEL_OFF  = 4'd0;
  localparam logic [LevelW-1:0] LEVEL_LOW  = 4'd4;
  localparam logic [LevelW-1:0] LEVEL_MID  = 4'd6;
  localparam logic [LevelW-1:0] LEVEL_HIGH = 4'd8;
  localparam logic [LevelW-1:0] LEVEL_FULL = 4'd10;

  // margin set: entry 0 is the widest (a), entry 3 the narrowest (d)
  typedef logic [3:0][MarginW-1:0] margin_set_t;

  localparam margin_set_t MarginLeftGraded  = '{6'(-10), 6'(0), 6'(10), 6'(15)};
  localparam margin_set_t MarginRightGraded = '{6'(-5),  6'(0), 6'(5),  6'(10)};
  localparam margin_set_t MarginPlain       = '{6'(0),   6'(15), 6'(15), 6'(15)};

  typedef struct packed {
    logic [AngleW-1:0] start;
    logic [AngleW-1:0] stop;
  } window_t;

endpackage

// ----- sv/casw_chan.sv -----
// One stimulation channel: tests the shifted angle against its window at
// four nested margins and picks the drive level.
// Depends on casw_pkg.
module casw_chan (
  input  logic [casw_pkg::ShiftW-1:0]  angle_i,
  input  casw_pkg::window_t            window_i,
  input  casw_pkg::margin_set_t        margins_i,
  output logic [casw_pkg::LevelW-1:0]  level_o
);
  import casw_pkg::*;

  localparam int CmpW = 12;

  logic signed [CmpW-1:0] ang_x;
  logic signed [CmpW-1:0] start_x;
  logic signed [CmpW-1:0] stop_x;
  logic                   wrap;
  logic [3:0]             in_win;

  assign ang_x   = $signed({{(CmpW-ShiftW){1'b0}}, angle_i});
  assign start_x = $signed({{(CmpW-AngleW){1'b0}}, window_i.start});
  assign stop_x  = $signed({{(CmpW-AngleW){1'b0}}, window_i.stop});
  // start at or past stop: window runs through zero
  assign wrap    = window_i.start >= window_i.stop;

  always_comb begin
    logic signed [CmpW-1:0] m_x;
    logic                   ge_lo;
    logic                   le_hi;
    for (int j = 0; j < 4; j++) begin
      m_x   = $signed({{(CmpW-MarginW){margins_i[j][MarginW-1]}}, margins_i[j]});
      ge_lo = ang_x >= (start_x - m_x);
      le_hi = ang_x <= (stop_x + m_x);
      in_win[j] = wrap ? (ge_lo | le_hi) : (ge_lo & le_hi);
    end
  end

  always_comb begin
    if (!in_win[0]) begin
      level_o = LEVEL_OFF;
    end else if (!in_win[1]) begin
      level_o = LEVEL_LOW;
    end else if (!in_win[2]) begin
      level_o = LEVEL_MID;
    end else if (!in_win[3]) begin
      level_o = LEVEL_HIGH;
    end else begin
      level_o = LEVEL_FULL;
    end
  end

endmodule

// ----- sv/crank_angle_stimulation_window.sv -----
// Top level of the crank angle stimulation window: configuration registers,
// input and result registers, and the per-channel window logic.
// Depends on casw_pkg and casw_chan.
//
//  channel | handshake                | payload
//  --------+--------------------------+-------------------------------------
//  cfg     | cfg_valid_i / cfg_ready_o| cfg_index_i, cfg_data_i
//  in      | in_valid_i / in_ready_o  | crank_angle_i
//  out     | out_valid_o / out_ready_i| left_level_0..3_o, right_level_0..3_o
//
// Two register stages: the angle is captured, then phase shift and all eight
// window tests run combinationally into the result register. One item per
// cycle while the result is not stalled. Reset clears valid flags and config.
// A stalled result holds; a new item is still taken while the input stage
// has room. Config writes are always taken.
module crank_angle_stimulation_window #(
  parameter int CHANNELS_PER_SIDE = casw_pkg::ChannelSlots
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [casw_pkg::CfgIndexW-1:0] cfg_index_i,
  input  logic [casw_pkg::CfgDataW-1:0]  cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [casw_pkg::AngleW-1:0]    crank_angle_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [casw_pkg::LevelW-1:0]    left_level_0_o,
  output logic [casw_pkg::LevelW-1:0]    left_level_1_o,
  output logic [casw_pkg::LevelW-1:0]    left_level_2_o,
  output logic [casw_pkg::LevelW-1:0]    left_level_3_o,
  output logic [casw_pkg::LevelW-1:0]    right_level_0_o,
  output logic [casw_pkg::LevelW-1:0]    right_level_1_o,
  output logic [casw_pkg::LevelW-1:0]    right_level_2_o,
  output logic [casw_pkg::LevelW-1:0]    right_level_3_o
);
  import casw_pkg::*;

  // configuration
  logic [AngleW-1:0]       phase_delay_q;
  logic [ChannelSlots-1:0] mod_mask_q;
  logic [CfgDataW-1:0]     left_start_q;
  logic [CfgDataW-1:0]     left_stop_q;
  logic [CfgDataW-1:0]     right_start_q;
  logic [CfgDataW-1:0]     right_stop_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_delay_q <= '0;
      mod_mask_q    <= '0;
      left_start_q  <= '0;
      left_stop_q   <= '0;
      right_start_q <= '0;
      right_stop_q  <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_PHASE_DELAY: phase_delay_q <= cfg_data_i[AngleW-1:0];
        REG_MOD_MASK:    mod_mask_q    <= cfg_data_i[ChannelSlots-1:0];
        REG_LEFT_START:  left_start_q  <= cfg_data_i;
        REG_LEFT_STOP:   left_stop_q   <= cfg_data_i;
        REG_RIGHT_START: right_start_q <= cfg_data_i;
        REG_RIGHT_STOP:  right_stop_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // pipeline control
  logic              s1_valid_q;
  logic [AngleW-1:0] s1_angle_q;
  logic              out_valid_q;
  logic              out_free;
  logic              s1_move;

  assign out_free   = !out_valid_q || out_ready_i;
  assign s1_move    = s1_valid_q && out_free;
  assign in_ready_o = !s1_valid_q || out_free;
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      s1_angle_q <= crank_angle_i;
    end
  end

  // phase shift, reduced by one turn at most
  logic [ShiftW-1:0] sum;
  logic [ShiftW-1:0] shifted;

  assign sum     = {1'b0, s1_angle_q} + {1'b0, phase_delay_q};
  assign shifted = (sum > FullTurn) ? (sum - FullTurn) : sum;

  logic [ChannelSlots-1:0][LevelW-1:0] left_lvl_d;
  logic [ChannelSlots-1:0][LevelW-1:0] right_lvl_d;
  logic [ChannelSlots-1:0][LevelW-1:0] left_lvl_q;
  logic [ChannelSlots-1:0][LevelW-1:0] right_lvl_q;

  for (genvar k = 0; k < ChannelSlots; k++) begin : g_chan
    if (k < CHANNELS_PER_SIDE) begin : g_used
      window_t     left_win;
      window_t     right_win;
      margin_set_t left_m;
      margin_set_t right_m;

      assign left_win.start  = left_start_q[k*AngleW +: AngleW];
      assign left_win.stop   = left_stop_q[k*AngleW +: AngleW];
      assign right_win.start = right_start_q[k*AngleW +: AngleW];
      assign right_win.stop  = right_stop_q[k*AngleW +: AngleW];
      assign left_m  = mod_mask_q[k] ? MarginLeftGraded  : MarginPlain;
      assign right_m = mod_mask_q[k] ? MarginRightGraded : MarginPlain;

      casw_chan u_left (
        .angle_i   (shifted),
        .window_i  (left_win),
        .margins_i (left_m),
        .level_o   (left_lvl_d[k])
      );

      casw_chan u_right (
        .angle_i   (shifted),
        .window_i  (right_win),
        .margins_i (right_m),
        .level_o   (right_lvl_d[k])
      );
    end else begin : g_unused
      assign left_lvl_d[k]  = LEVEL_OFF;
      assign right_lvl_d[k] = LEVEL_OFF;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_move) begin
      left_lvl_q  <= left_lvl_d;
      right_lvl_q <= right_lvl_d;
    end
  end

  assign left_level_0_o  = left_lvl_q[0];
  assign left_level_1_o  = left_lvl_q[1];
  assign left_level_2_o  = left_lvl_q[2];
  assign left_level_3_o  = left_lvl_q[3];
  assign right_level_0_o = right_lvl_q[0];
  assign right_level_1_o = right_lvl_q[1];
  assign right_level_2_o = right_lvl_q[2];
  assign right_level_3_o = right_lvl_q[3];

  // input stage only refuses an item when it is full and the result is stuck
  a_ready_only_when_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (s1_valid_q && out_valid_q && !out_ready_i))
    else $error("input stalled without a blocked result");

  // a pending item in the input stage moves to the result when it is taken
  a_refill : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && s1_valid_q) |=> out_valid_o)
    else $error("pending item lost on result hand-over");

  // left channel 0 only ever carries a legal drive level
  a_left_level_legal : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (left_level_0_o == LEVEL_OFF || left_level_0_o == LEVEL_LOW ||
                     left_level_0_o == LEVEL_MID || left_level_0_o == LEVEL_HIGH ||
                     left_level_0_o == LEVEL_FULL))
    else $error("illegal left drive level");

  // right channel 0 only ever carries a legal drive level
  a_right_level_legal : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (right_level_0_o == LEVEL_OFF || right_level_0_o == LEVEL_LOW ||
                     right_level_0_o == LEVEL_MID || right_level_0_o == LEVEL_HIGH ||
                     right_level_0_o == LEVEL_FULL))
    else $error("illegal right drive level");

endmodule

// ----- dv/crank_angle_stimulation_window_tb.sv -----
// Self-checking testbench for crank_angle_stimulation_window: random and directed
// crank angles and register settings, with results checked against a local level predictor.
// Depends on casw_pkg and the RTL of the block.
module crank_angle_stimulation_window_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import casw_pkg::*;

  localparam int ChannelsPerSide = 4;
  localparam int TurnDeg         = 360;
  localparam int RandomPhases    = 19;
  localparam int ItemsPerPhase   = 100;
  localparam int MaxIdle         = 5;

  // indexes that decode to no register
  localparam logic [CfgIndexW-1:0] REG_UNUSED_LO = 3'd6;
  localparam logic [CfgIndexW-1:0] REG_UNUSED_HI = 3'd7;

  typedef enum logic [1:0] {OP_ITEM, OP_CFG, OP_DRAIN} op_kind_e;

  typedef struct {
    op_kind_e               kind;
    logic [AngleW-1:0]      angle;
    logic [CfgIndexW-1:0]   index;
    logic [CfgDataW-1:0]    data;
    int                     gap;
  } pending_op_t;

  // left channels 0..3 in entries 0..3, right channels in 4..7
  typedef logic [7:0][LevelW-1:0] levels_t;

  logic                 clk_i         = 1'b0;
  logic                 rst_ni        = 1'b0;
  logic                 cfg_valid_i   = 1'b0;
  logic                 cfg_ready_o;
  logic [CfgIndexW-1:0] cfg_index_i   = '0;
  logic [CfgDataW-1:0]  cfg_data_i    = '0;
  logic                 in_valid_i    = 1'b0;
  logic                 in_ready_o;
  logic [AngleW-1:0]    crank_angle_i = '0;
  logic                 out_valid_o;
  logic                 out_ready_i   = 1'b1;
  levels_t              levels_o;

  crank_angle_stimulation_window #(
    .CHANNELS_PER_SIDE(ChannelsPerSide)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .crank_angle_i  (crank_angle_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .left_level_0_o (levels_o[0]),
    .left_level_1_o (levels_o[1]),
    .left_level_2_o (levels_o[2]),
    .left_level_3_o (levels_o[3]),
    .right_level_0_o(levels_o[4]),
    .right_level_1_o(levels_o[5]),
    .right_level_2_o(levels_o[6]),
    .right_level_3_o(levels_o[7])
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // predictor copy of the registers
  logic [AngleW-1:0]   delay_q;
  logic [3:0]          mask_q;
  logic [CfgDataW-1:0] left_start_q, left_stop_q, right_start_q, right_stop_q;

  pending_op_t op_q[$];
  levels_t     expected_levels_q[$];
  int unsigned angles_accepted = 0;
  int unsigned results_checked = 0;
  int unsigned reg_writes      = 0;
  int unsigned errors          = 0;
  int          gap_count       = 0;
  int          stall_count     = 0;
  bit          sender_calm     = 1'b0;
  bit          receiver_calm   = 1'b0;

  function automatic int lane(logic [CfgDataW-1:0] word, int k);
    return int'(word[k*AngleW +: AngleW]);
  endfunction

  // start at or past stop means the window wraps through zero
  function automatic bit in_window(int ang, int s, int e, int m);
    if (s < e) return (ang >= s - m) && (ang <= e + m);
    return (ang >= s - m) || (ang <= e + m);
  endfunction

  function automatic logic [LevelW-1:0] drive_level(int ang, int s, int e, input int mg[4]);
    if (!in_window(ang, s, e, mg[0])) return LEVEL_OFF;
    if (!in_window(ang, s, e, mg[1])) return LEVEL_LOW;
    if (!in_window(ang, s, e, mg[2])) return LEVEL_MID;
    if (!in_window(ang, s, e, mg[3])) return LEVEL_HIGH;
    return LEVEL_FULL;
  endfunction

  function automatic levels_t predict_levels(logic [AngleW-1:0] crank);
    levels_t lv;
    int      shifted;
    int      k;
    int      mg_left[4];
    int      mg_right[4];
    lv = '0;
    shifted = int'(crank) + int'(delay_q);
    if (shifted > TurnDeg) shifted -= TurnDeg;
    for (k = 0; k < ChannelsPerSide; k++) begin
      if (mask_q[k]) begin
        mg_left  = '{15, 10, 0, -10};
        mg_right = '{10, 5, 0, -5};
      end else begin
        mg_left  = '{15, 15, 15, 0};
        mg_right = mg_left;
      end
      lv[k]     = drive_level(shifted, lane(left_start_q, k), lane(left_stop_q, k), mg_left);
      lv[k + 4] = drive_level(shifted, lane(right_start_q, k), lane(right_stop_q, k),
                              mg_right);
    end
    return lv;
  endfunction

  // sender: one item or register write at a time, idle cycles drawn per item
  always @(posedge clk_i) begin
    pending_op_t head;
    int unsigned acc_next;
    acc_next = angles_accepted + ((in_valid_i && in_ready_o) ? 1 : 0);
    if (!rst_ni) begin
      in_valid_i  <= 1'b0;
      cfg_valid_i <= 1'b0;
      gap_count   <= 0;
    end else begin
      angles_accepted <= acc_next;
      if ((in_valid_i && !in_ready_o) || (cfg_valid_i && !cfg_ready_o)) begin
        // hold until taken
      end else if (op_q.size() == 0) begin
        in_valid_i  <= 1'b0;
        cfg_valid_i <= 1'b0;
      end else begin
        head = op_q[0];
        if (head.kind == OP_ITEM) begin
          cfg_valid_i <= 1'b0;
          if (gap_count < head.gap) begin
            in_valid_i <= 1'b0;
            gap_count  <= gap_count + 1;
          end else begin
            in_valid_i    <= 1'b1;
            crank_angle_i <= head.angle;
            gap_count     <= 0;
            void'(op_q.pop_front());
          end
        end else begin
          in_valid_i <= 1'b0;
          if (acc_next != results_checked) begin
            cfg_valid_i <= 1'b0;   // block still busy
          end else if (head.kind == OP_CFG) begin
            cfg_valid_i <= 1'b1;
            cfg_index_i <= head.index;
            cfg_data_i  <= head.data;
            void'(op_q.pop_front());
          end else begin
            cfg_valid_i <= 1'b0;
            void'(op_q.pop_front());
          end
        end
      end
    end
  end

  // monitor: tracks register writes, predicts accepted items, checks results
  always @(posedge clk_i) begin
    levels_t want;
    int      stall;
    int      k;
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) begin
        reg_writes++;
        case (cfg_index_i)
          REG_PHASE_DELAY: delay_q       = cfg_data_i[AngleW-1:0];
          REG_MOD_MASK:    mask_q        = cfg_data_i[3:0];
          REG_LEFT_START:  left_start_q  = cfg_data_i;
          REG_LEFT_STOP:   left_stop_q   = cfg_data_i;
          REG_RIGHT_START: right_start_q = cfg_data_i;
          REG_RIGHT_STOP:  right_stop_q  = cfg_data_i;
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_o) expected_levels_q.push_back(predict_levels(crank_angle_i));
      if (out_valid_o && out_ready_i) begin
        results_checked <= results_checked + 1;
        if (expected_levels_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected result, expected none, got %h", $time, levels_o);
        end else begin
          want = expected_levels_q.pop_front();
          for (k = 0; k < 8; k++) begin
            if (levels_o[k] !== want[k]) begin
              errors++;
              $display("%0t: %s_level_%0d expected %0d got %0d", $time,
                       (k < 4) ? "left" : "right", k % 4, want[k], levels_o[k]);
            end
          end
        end
        if (results_checked % 50 == 0) receiver_calm = ($urandom_range(0, 3) == 0);
        stall = receiver_calm ? 0 : $urandom_range(0, MaxIdle);
        if (stall == 0) begin
          out_ready_i <= 1'b1;
        end else begin
          out_ready_i <= 1'b0;
          stall_count <= stall;
        end
      end else if (stall_count != 0) begin
        stall_count <= stall_count - 1;
        if (stall_count == 1) out_ready_i <= 1'b1;
      end
    end else begin
      delay_q       = '0;
      mask_q        = '0;
      left_start_q  = '0;
      left_stop_q   = '0;
      right_start_q = '0;
      right_stop_q  = '0;
    end
  end

  task automatic add_item(int angle);
    pending_op_t op;
    op.kind  = OP_ITEM;
    op.angle = AngleW'(angle);
    op.index = '0;
    op.data  = '0;
    op.gap   = sender_calm ? 0 : $urandom_range(0, MaxIdle);
    op_q.push_back(op);
  endtask

  task automatic add_cfg(logic [CfgIndexW-1:0] index, logic [CfgDataW-1:0] data);
    pending_op_t op;
    op.kind  = (index == REG_UNUSED_LO && data === 'x) ? OP_DRAIN : OP_CFG;
    op.angle = '0;
    op.index = index;
    op.data  = data;
    op.gap   = 0;
    op_q.push_back(op);
  endtask

  task automatic add_drain();
    pending_op_t op;
    op.kind  = OP_DRAIN;
    op.angle = '0;
    op.index = '0;
    op.data  = '0;
    op.gap   = 0;
    op_q.push_back(op);
  endtask

  // window edge: mostly a real angle, sometimes past a full turn
  function automatic int random_edge();
    if ($urandom_range(0, 9) == 0) return $urandom_range(TurnDeg + 1, 511);
    return $urandom_range(0, TurnDeg);
  endfunction

  function automatic logic [CfgDataW-1:0] random_window_set();
    logic [CfgDataW-1:0] word;
    int                  k;
    for (k = 0; k < 4; k++) word[k*AngleW +: AngleW] = AngleW'(random_edge());
    return word;
  endfunction

  function automatic logic [CfgDataW-1:0] with_junk(int val);
    return {27'($urandom), AngleW'(val)};
  endfunction

  initial begin
    logic [CfgDataW-1:0] starts, stops, edges;
    int                  phase, n, delay, pick, angle, drain_at;

    // reset settings: every window has equal start and stop, so it wraps
    sender_calm = 1'b1;
    add_item(0);
    add_item(TurnDeg);
    add_item(511);

    // normal, wrapping and out-of-range windows on each side, an equal one on the left
    add_cfg(REG_PHASE_DELAY, '0);
    add_cfg(REG_MOD_MASK, 36'h5);
    add_cfg(REG_LEFT_START,  {9'd511, 9'd200, 9'd300, 9'd90});
    add_cfg(REG_LEFT_STOP,   {9'd400, 9'd200, 9'd30,  9'd180});
    add_cfg(REG_RIGHT_START, {9'd100, 9'd0,   9'd350, 9'd10});
    add_cfg(REG_RIGHT_STOP,  {9'd101, 9'd511, 9'd10,  9'd350});
    sender_calm = 1'b0;
    add_item(75);  add_item(80);  add_item(85);  add_item(95);
    add_item(180); add_item(185); add_item(195); add_item(196);
    add_item(300); add_item(30);  add_item(200);
    // sum past a full turn, and a delay beyond 360 that still leaves > 360
    add_cfg(REG_PHASE_DELAY, 36'd360);
    add_cfg(REG_MOD_MASK, 36'hF);
    add_item(0);   add_item(1);   add_item(TurnDeg); add_item(511);
    add_cfg(REG_PHASE_DELAY, {27'h7FFFFFF, 9'd511});
    add_cfg(REG_MOD_MASK, 36'hFFFFFFFF0);
    add_item(0);   add_item(511);
    add_cfg(REG_UNUSED_LO, '1);
    add_cfg(REG_UNUSED_HI, '1);
    add_item(150); add_item(330);
    delay = 511;

    for (phase = 0; phase < RandomPhases; phase++) begin
      sender_calm = ($urandom_range(0, 3) == 0);
      // a phase without a delay write keeps the previous delay
      if (phase == 0 || $urandom_range(0, 1)) begin
        pick = $urandom_range(0, 5);
        delay = (pick == 0) ? 0 : (pick == 1) ? TurnDeg : (pick == 2) ? 511
                : $urandom_range(0, TurnDeg);
        add_cfg(REG_PHASE_DELAY, with_junk(delay));
      end
      pick = $urandom_range(0, 3);
      add_cfg(REG_MOD_MASK, (pick == 0) ? with_junk(0) : (pick == 1) ? with_junk(15)
              : with_junk($urandom_range(0, 15)));
      starts = random_window_set();
      stops  = random_window_set();
      if ($urandom_range(0, 3) == 0) stops[AngleW-1:0] = starts[AngleW-1:0];
      add_cfg(REG_LEFT_START, starts);
      add_cfg(REG_LEFT_STOP, stops);
      edges = starts;
      starts = random_window_set();
      stops  = random_window_set();
      if ($urandom_range(0, 3) == 0) stops[2*AngleW +: AngleW] = starts[2*AngleW +: AngleW];
      add_cfg(REG_RIGHT_START, starts);
      add_cfg(REG_RIGHT_STOP, stops);
      if ($urandom_range(0, 4) == 0)
        add_cfg($urandom_range(0, 1) ? REG_UNUSED_LO : REG_UNUSED_HI,
                {4'($urandom), 32'($urandom)});
      drain_at = ($urandom_range(0, 2) == 0) ? $urandom_range(1, ItemsPerPhase - 1) : -1;
      for (n = 0; n < ItemsPerPhase; n++) begin
        if (n == drain_at) add_drain();
        pick = $urandom_range(0, 9);
        if (pick < 6) begin
          angle = $urandom_range(0, TurnDeg);
        end else if (pick < 9) begin
          // close to a window edge after the phase shift
          case ($urandom_range(0, 3))
            0: angle = lane(edges, $urandom_range(0, 3));
            1: angle = lane(stops, $urandom_range(0, 3));
            2: angle = lane(starts, $urandom_range(0, 3));
            default: angle = $urandom_range(0, TurnDeg);
          endcase
          angle = angle + $urandom_range(0, 40) - 20 - (delay % 512);
          while (angle < 0) angle += TurnDeg;
          angle = angle % (TurnDeg + 1);
        end else begin
          angle = $urandom_range(0, 511);
        end
        add_item(angle);
      end
    end

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    do @(posedge clk_i);
    while (op_q.size() != 0 || in_valid_i || cfg_valid_i || angles_accepted != results_checked);
    repeat (8) @(posedge clk_i);
    if (expected_levels_q.size() != 0) begin
      errors += expected_levels_q.size();
      $display("%0t: %0d results expected but never seen", $time, expected_levels_q.size());
    end

    $display("Sent %0d crank angles over %0d register writes (phase shifts, masks, windows),",
             angles_accepted, reg_writes);
    $display("and compared %0d sets of eight drive levels.", results_checked);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("%0t: timeout", $time);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// ----- filelist.f -----
sv/casw_pkg.sv
sv/casw_chan.sv
sv/crank_angle_stimulation_window.sv
dv/crank_angle_stimulation_window_tb.sv
